@@ rtl/stcf_pkg.sv @@
// Shared types and codes for the STCF thread scheduler.
package stcf_pkg;

    localparam int MaxThreadsDef  = 16;
    localparam int ElapsedBitsDef = 16;

    // Event codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_YIELD  = 3'd1;
    localparam logic [2:0] OP_EXIT   = 3'd2;
    localparam logic [2:0] OP_JOIN   = 3'd3;
    localparam logic [2:0] OP_BLOCK  = 3'd4;
    localparam logic [2:0] OP_WAKE   = 3'd5;
    localparam logic [2:0] OP_CREATE = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_DEADLOCK = 3'd2;
    localparam logic [2:0] ST_ALL_DONE = 3'd3;
    localparam logic [2:0] ST_NO_ID    = 3'd4;

    typedef enum logic [1:0] {
        TS_FREE,
        TS_ACTIVE,
        TS_JOINING,
        TS_BLOCKED
    } t_tstate;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_EXEC,
        FS_WALK,
        FS_INS,
        FS_POP,
        FS_FIN
    } t_fsm;

    typedef enum logic [1:0] {
        QC_NOP,
        QC_INS,
        QC_POP,
        QC_FRONT
    } t_qop;

    // Queue command shared by all cells
    typedef struct packed {
        t_qop op;
        logic behind;
    } t_qctl;

endpackage

@@ rtl/stcf_cell.sv @@
// One slot of the sorted ready queue: holds a thread id and its elapsed key.
module stcf_cell
    import stcf_pkg::*;
#(
    parameter int ID_W = 4,
    parameter int EB   = 16
) (
    input  logic            i_clk,
    input  t_qctl           i_ctl,
    input  logic [ID_W-1:0] i_new_id,
    input  logic [EB-1:0]   i_new_key,
    input  logic            i_valid,
    input  logic            i_prev_stay,
    input  logic [ID_W-1:0] i_prev_id,
    input  logic [EB-1:0]   i_prev_key,
    input  logic [ID_W-1:0] i_next_id,
    input  logic [EB-1:0]   i_next_key,
    output logic            o_stay,
    output logic [ID_W-1:0] o_id,
    output logic [EB-1:0]   o_key
);

    logic [ID_W-1:0] r_id;
    logic [EB-1:0]   r_key;

    // Entry stays ahead of the incoming thread
    always_comb begin
        o_stay = 1'b0;
        if (i_valid && i_ctl.op == QC_INS) begin
            o_stay = i_ctl.behind ? (r_key <= i_new_key) : (r_key < i_new_key);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            QC_INS, QC_FRONT: begin
                if (!o_stay) begin
                    if (i_prev_stay) begin
                        r_id  <= i_new_id;
                        r_key <= i_new_key;
                    end else begin
                        r_id  <= i_prev_id;
                        r_key <= i_prev_key;
                    end
                end
            end
            QC_POP: begin
                r_id  <= i_next_id;
                r_key <= i_next_key;
            end
            default: ;
        endcase
    end

    assign o_id  = r_id;
    assign o_key = r_key;

endmodule

@@ rtl/stcf_queue.sv @@
// Ready queue: a chain of cells kept sorted by elapsed count, plus its fill count.
module stcf_queue
    import stcf_pkg::*;
#(
    parameter int MAX_THREADS = MaxThreadsDef,
    parameter int EB          = ElapsedBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_qctl                         i_ctl,
    input  logic [$clog2(MAX_THREADS)-1:0] i_id,
    input  logic [EB-1:0]                 i_key,
    output logic [$clog2(MAX_THREADS)-1:0] o_head_id,
    output logic [EB-1:0]                 o_head_key,
    output logic [$clog2(MAX_THREADS):0]  o_count
);

    localparam int ID_W = $clog2(MAX_THREADS);
    localparam int CW   = ID_W + 1;

    logic [CW-1:0]   r_count;
    logic            full;
    t_qctl           ctl;
    logic            stay [MAX_THREADS];
    logic [ID_W-1:0] ids  [MAX_THREADS];
    logic [EB-1:0]   keys [MAX_THREADS];

    assign full = (r_count == CW'(MAX_THREADS));

    // Inserts into a full queue are dropped
    always_comb begin
        ctl = i_ctl;
        if (full && (i_ctl.op == QC_INS || i_ctl.op == QC_FRONT)) begin
            ctl.op = QC_NOP;
        end
    end

    // Cell chain
    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
        logic            prev_stay;
        logic [ID_W-1:0] prev_id;
        logic [EB-1:0]   prev_key;
        logic [ID_W-1:0] next_id;
        logic [EB-1:0]   next_key;

        if (g == 0) begin : g_first
            assign prev_stay = 1'b1;
            assign prev_id   = i_id;
            assign prev_key  = i_key;
        end else begin : g_mid
            assign prev_stay = stay[g-1];
            assign prev_id   = ids[g-1];
            assign prev_key  = keys[g-1];
        end
        if (g == MAX_THREADS - 1) begin : g_last
            assign next_id  = ids[g];
            assign next_key = keys[g];
        end else begin : g_nx
            assign next_id  = ids[g+1];
            assign next_key = keys[g+1];
        end

        stcf_cell #(
            .ID_W(ID_W),
            .EB  (EB)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_new_id   (i_id),
            .i_new_key  (i_key),
            .i_valid    (CW'(g) < r_count),
            .i_prev_stay(prev_stay),
            .i_prev_id  (prev_id),
            .i_prev_key (prev_key),
            .i_next_id  (next_id),
            .i_next_key (next_key),
            .o_stay     (stay[g]),
            .o_id       (ids[g]),
            .o_key      (keys[g])
        );
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (ctl.op)
                QC_INS, QC_FRONT: r_count <= r_count + 1'b1;
                QC_POP:           r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_head_id  = ids[0];
    assign o_head_key = keys[0];
    assign o_count    = r_count;

endmodule

@@ rtl/stcf_thread_scheduler.sv @@
// Top level: event sequencer, per-thread tables and result register.
//
//  channel | signals                                        | dir
//  event   | i_valid o_ready i_opcode i_thread_id i_hold     | in
//  result  | o_valid i_ready o_running_id o_running_valid    | out
//          | o_switched o_new_id o_status                    |
//
// An event passes through decode, an optional queue insert, an optional
// queue pop and the result step; a join adds one walk step per thread on its
// wait chain, up to MAX_THREADS. The queue shifts all its cells at once.
// Reset is synchronous and clears all thread tables at once.
// A result still waiting in the output register holds the sequencer in its
// last step, and no new event is taken until that result drains.
module stcf_thread_scheduler
    import stcf_pkg::*;
#(
    parameter int MAX_THREADS  = MaxThreadsDef,
    parameter int ELAPSED_BITS = ElapsedBitsDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [3:0] i_thread_id,
    input  logic       i_hold,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_running_id,
    output logic       o_running_valid,
    output logic       o_switched,
    output logic [3:0] o_new_id,
    output logic [2:0] o_status
);

    localparam int ID_W = $clog2(MAX_THREADS);
    localparam int CW   = ID_W + 1;
    localparam int EB   = ELAPSED_BITS;

    t_fsm r_fsm, n_fsm;

    // Event registers
    logic [2:0]      r_op;
    logic [3:0]      r_tid;
    logic            r_hold;

    // Scheduler state
    t_tstate         r_tstate  [MAX_THREADS];
    logic [EB-1:0]   r_elapsed [MAX_THREADS];
    logic [CW-1:0]   r_joiner  [MAX_THREADS];
    logic [ID_W-1:0] r_cur;
    logic [CW-1:0]   r_nfree;
    logic            r_started;

    // Per-event bookkeeping
    logic            r_do_pop, r_front, r_behind;
    logic [ID_W-1:0] r_ins_id;
    logic [EB-1:0]   r_ins_key;
    logic [2:0]      r_status;
    logic [ID_W-1:0] r_new_id;
    logic            r_was_valid;
    logic [ID_W-1:0] r_was_id;
    logic [ID_W-1:0] r_walk;
    logic [ID_W-1:0] r_steps;

    // Result register
    logic            r_out_valid;
    logic [3:0]      r_out_run_id;
    logic            r_out_run_v, r_out_sw;
    logic [3:0]      r_out_new_id;
    logic [2:0]      r_out_status;

    // Queue interface
    t_qctl           q_ctl;
    logic [ID_W-1:0] q_head_id;
    logic [EB-1:0]   q_head_key;
    logic [CW-1:0]   q_count;

    stcf_queue #(
        .MAX_THREADS(MAX_THREADS),
        .EB         (EB)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_id      (r_ins_id),
        .i_key     (r_ins_key),
        .o_head_id (q_head_id),
        .o_head_key(q_head_key),
        .o_count   (q_count)
    );

    // Common decode terms
    logic            running, q_any, tid_ok;
    logic [ID_W-1:0] tid_idx, w_id;
    logic [EB-1:0]   e_cur, e_b;
    logic [CW-1:0]   need, j_cur;
    logic [CW:0]     nfree_sum;

    assign running   = r_started && r_tstate[r_cur] == TS_ACTIVE;
    assign q_any     = q_count != '0;
    assign tid_ok    = (CW+4)'(r_tid) < (CW+4)'(MAX_THREADS);
    assign tid_idx   = ID_W'(r_tid);
    assign e_cur     = r_elapsed[r_cur];
    assign e_b       = (e_cur == {EB{1'b1}}) ? e_cur : e_cur + 1'b1;
    assign j_cur     = r_joiner[r_cur];
    assign w_id      = ID_W'(j_cur - 1'b1);
    assign need      = r_started ? CW'(1) : CW'(2);
    assign nfree_sum = {1'b0, r_nfree} + {1'b0, need};

    // Decode of one event: queue work and outcome
    logic d_ins, d_pop, d_front, d_behind, d_walk;
    logic [ID_W-1:0] d_ins_id;
    logic [EB-1:0]   d_ins_key;
    logic [2:0]      d_status;

    always_comb begin
        d_ins     = 1'b0;
        d_pop     = 1'b0;
        d_front   = 1'b0;
        d_behind  = 1'b0;
        d_walk    = 1'b0;
        d_ins_id  = r_cur;
        d_ins_key = e_b;
        d_status  = ST_OK;
        if (r_op <= OP_BLOCK && !running) begin
            d_status = ST_REJECTED;
        end else begin
            case (r_op)
                OP_TICK: begin
                    if (!r_hold && q_any && e_b > q_head_key) begin
                        d_ins = 1'b1;
                        d_pop = 1'b1;
                    end
                end
                OP_YIELD: begin
                    if (q_any && e_b >= q_head_key) begin
                        d_ins    = 1'b1;
                        d_pop    = 1'b1;
                        d_behind = 1'b1;
                    end
                end
                OP_EXIT: begin
                    if (j_cur != '0) begin
                        d_ins_id  = w_id;
                        d_ins_key = r_elapsed[w_id];
                        if (q_any && r_elapsed[w_id] > q_head_key) begin
                            d_ins = 1'b1;
                            d_pop = 1'b1;
                        end
                    end else if (q_any) begin
                        d_pop = 1'b1;
                    end else begin
                        d_status = ST_ALL_DONE;
                    end
                end
                OP_JOIN: begin
                    if (!tid_ok || tid_idx == r_cur || r_joiner[tid_idx] != '0) begin
                        d_status = ST_REJECTED;
                    end else begin
                        d_walk = 1'b1;
                    end
                end
                OP_BLOCK: begin
                    if (q_any) d_pop = 1'b1;
                    else       d_status = ST_DEADLOCK;
                end
                OP_WAKE: begin
                    if (!tid_ok || r_tstate[tid_idx] != TS_BLOCKED) begin
                        d_status = ST_REJECTED;
                    end else if (running) begin
                        d_ins     = 1'b1;
                        d_ins_id  = tid_idx;
                        d_ins_key = r_elapsed[tid_idx];
                    end
                end
                OP_CREATE: begin
                    if (nfree_sum > (CW+1)'(MAX_THREADS)) begin
                        d_status = ST_NO_ID;
                    end else if (!r_started || running) begin
                        d_ins     = 1'b1;
                        d_front   = 1'b1;
                        d_ins_id  = ID_W'(r_nfree);
                        d_ins_key = '0;
                    end
                end
                default: d_status = ST_REJECTED;
            endcase
        end
    end

    // Join chain walk: one thread per cycle
    logic            w_done, w_ok, w_found;
    logic [ID_W-1:0] w_next;

    always_comb begin
        w_found = 1'b0;
        w_next  = '0;
        for (int x = MAX_THREADS - 1; x >= 0; x--) begin
            if (r_joiner[x] == CW'(r_walk) + 1'b1) begin
                w_found = 1'b1;
                w_next  = ID_W'(x);
            end
        end
        w_done = 1'b1;
        w_ok   = 1'b0;
        case (r_tstate[r_walk])
            TS_ACTIVE:  w_ok = r_walk != r_cur;
            TS_BLOCKED: w_ok = 1'b1;
            TS_JOINING: w_done = !w_found || r_steps == ID_W'(MAX_THREADS - 1);
            default:    w_ok = 1'b0;
        endcase
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fsm <= FS_IDLE;
        else          r_fsm <= n_fsm;
    end

    // Next state and queue command
    always_comb begin
        n_fsm        = r_fsm;
        q_ctl.op     = QC_NOP;
        q_ctl.behind = r_behind;
        case (r_fsm)
            FS_IDLE: if (i_valid) n_fsm = FS_EXEC;
            FS_EXEC: begin
                if (d_walk)     n_fsm = FS_WALK;
                else if (d_ins) n_fsm = FS_INS;
                else if (d_pop) n_fsm = FS_POP;
                else            n_fsm = FS_FIN;
            end
            FS_WALK: begin
                if (w_done) n_fsm = (w_ok && q_any) ? FS_POP : FS_FIN;
            end
            FS_INS: begin
                q_ctl.op = r_front ? QC_FRONT : QC_INS;
                n_fsm    = r_do_pop ? FS_POP : FS_FIN;
            end
            FS_POP: begin
                q_ctl.op = QC_POP;
                n_fsm    = FS_FIN;
            end
            FS_FIN: if (!r_out_valid || i_ready) n_fsm = FS_IDLE;
            default: n_fsm = FS_IDLE;
        endcase
    end

    // Event capture and per-event registers
    always_ff @(posedge i_clk) begin
        if (r_fsm == FS_IDLE && i_valid) begin
            r_op   <= i_opcode;
            r_tid  <= i_thread_id;
            r_hold <= i_hold;
        end
        if (r_fsm == FS_EXEC) begin
            r_do_pop    <= d_pop;
            r_front     <= d_front;
            r_behind    <= d_behind;
            r_ins_id    <= d_ins_id;
            r_ins_key   <= d_ins_key;
            r_status    <= d_status;
            r_was_valid <= running;
            r_was_id    <= r_cur;
            r_walk      <= tid_idx;
            r_steps     <= '0;
            r_new_id    <= '0;
            if (r_op == OP_CREATE && d_status == ST_OK) r_new_id <= ID_W'(r_nfree);
        end
        if (r_fsm == FS_WALK) begin
            r_walk  <= w_next;
            r_steps <= r_steps + 1'b1;
            if (w_done) begin
                if (!w_ok)       r_status <= ST_REJECTED;
                else if (!q_any) r_status <= ST_DEADLOCK;
            end
        end
    end

    // Thread tables and running thread
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < MAX_THREADS; t++) begin
                r_tstate[t]  <= TS_FREE;
                r_elapsed[t] <= '0;
                r_joiner[t]  <= '0;
            end
            r_cur     <= '0;
            r_nfree   <= '0;
            r_started <= 1'b0;
        end else begin
            case (r_fsm)
                FS_EXEC: begin
                    if (!(r_op <= OP_BLOCK && !running)) begin
                        case (r_op)
                            OP_TICK, OP_YIELD: r_elapsed[r_cur] <= e_b;
                            OP_EXIT: begin
                                r_tstate[r_cur] <= TS_FREE;
                                r_joiner[r_cur] <= '0;
                                if (j_cur != '0) begin
                                    r_tstate[w_id] <= TS_ACTIVE;
                                    r_cur          <= w_id;
                                end
                            end
                            OP_BLOCK: begin
                                r_elapsed[r_cur] <= e_b;
                                r_tstate[r_cur]  <= TS_BLOCKED;
                            end
                            OP_WAKE: begin
                                if (d_status == ST_OK) begin
                                    r_tstate[tid_idx] <= TS_ACTIVE;
                                    if (!running) r_cur <= tid_idx;
                                end
                            end
                            OP_CREATE: begin
                                if (d_status == ST_OK) begin
                                    r_tstate[ID_W'(r_nfree)]  <= TS_ACTIVE;
                                    r_elapsed[ID_W'(r_nfree)] <= '0;
                                    r_joiner[ID_W'(r_nfree)]  <= '0;
                                    if (!r_started) begin
                                        r_tstate[ID_W'(r_nfree + 1'b1)]  <= TS_ACTIVE;
                                        r_elapsed[ID_W'(r_nfree + 1'b1)] <= '0;
                                        r_joiner[ID_W'(r_nfree + 1'b1)]  <= '0;
                                        r_cur     <= ID_W'(r_nfree + 1'b1);
                                        r_started <= 1'b1;
                                    end else if (!running) begin
                                        r_cur <= ID_W'(r_nfree);
                                    end
                                    r_nfree <= CW'(nfree_sum);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                FS_WALK: begin
                    if (w_done && w_ok) begin
                        r_joiner[ID_W'(r_tid)] <= CW'(r_cur) + 1'b1;
                        r_tstate[r_cur]        <= TS_JOINING;
                        r_elapsed[r_cur]       <= e_b;
                    end
                end
                FS_POP: r_cur <= q_head_id;
                default: ;
            endcase
        end
    end

    // Result register
    logic now_valid;
    assign now_valid = running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_fsm == FS_FIN && (!r_out_valid || i_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == FS_FIN && (!r_out_valid || i_ready)) begin
            r_out_run_id <= now_valid ? 4'(r_cur) : 4'd0;
            r_out_run_v  <= now_valid;
            r_out_sw     <= (now_valid != r_was_valid) || (now_valid && r_cur != r_was_id);
            r_out_new_id <= 4'(r_new_id);
            r_out_status <= r_status;
        end
    end

    assign o_ready         = r_fsm == FS_IDLE;
    assign o_valid         = r_out_valid;
    assign o_running_id    = r_out_run_id;
    assign o_running_valid = r_out_run_v;
    assign o_switched      = r_out_sw;
    assign o_new_id        = r_out_new_id;
    assign o_status        = r_out_status;

endmodule
